// ----- design/bsfb_pkg.sv -----
package bsfb_pkg;

    // Operation codes carried by the op field of an input item.
    localparam logic OpStart   = 1'b0;
    localparam logic OpPayload = 1'b1;

    // Number of zero bytes that open every frame header.
    localparam int HeaderZeros = 2;

    // Most result bytes that one input item can cause.
    localparam int MaxResults = 7;
    localparam int IdxW       = $clog2(MaxResults);

    // Position of each byte within the results of a start item.
    localparam logic [IdxW-1:0] SlotId    = IdxW'(HeaderZeros);
    localparam logic [IdxW-1:0] SlotSeqLo = IdxW'(HeaderZeros + 1);
    localparam logic [IdxW-1:0] SlotSeqHi = IdxW'(HeaderZeros + 2);
    localparam logic [IdxW-1:0] SlotLen   = IdxW'(HeaderZeros + 3);
    localparam logic [IdxW-1:0] SlotSum   = IdxW'(HeaderZeros + 4);

    // Result counts of the different kinds of item.
    localparam logic [IdxW-1:0] CntStartOpen  = IdxW'(HeaderZeros + 4);
    localparam logic [IdxW-1:0] CntStartEmpty = IdxW'(HeaderZeros + 5);
    localparam logic [IdxW-1:0] CntOne        = IdxW'(1);
    localparam logic [IdxW-1:0] CntTwo        = IdxW'(2);

    typedef struct packed {
        logic        op;
        logic [7:0]  frame_id;
        logic [15:0] sequence_req;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       stray_byte;
    } t_result;

endpackage

// ----- design/bsfb_in_reg.sv -----
// Holds one accepted input item until the emitter has issued all of its results.
module bsfb_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bsfb_pkg::t_item i_item,
    input  logic          i_done,
    output logic          o_stall,
    output logic          o_item_valid,
    output bsfb_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    bsfb_pkg::t_item r_item;
    logic            load;

    // The register frees up in the same cycle its last result leaves.
    assign o_stall = r_valid && !i_done;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_done) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ----- design/bsfb_emit.sv -----
// Issues the result bytes of the held item one per advance and keeps the frame state.
module bsfb_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  bsfb_pkg::t_item   i_item,
    input  logic              i_advance,
    output logic              o_res_valid,
    output bsfb_pkg::t_result o_res,
    output logic              o_done
);

    logic                       r_frame_open;
    logic [7:0]                 r_bytes_left;
    logic [7:0]                 r_running_sum;
    logic [bsfb_pkg::IdxW-1:0]  r_idx;
    logic                       n_frame_open;
    logic [7:0]                 n_bytes_left;
    logic [7:0]                 n_running_sum;
    logic [bsfb_pkg::IdxW-1:0]  n_idx;
    logic [bsfb_pkg::IdxW-1:0]  count;
    logic [7:0]                 start_sum;
    logic [7:0]                 payload_sum;
    logic                       last;

    assign start_sum = i_item.frame_id + i_item.sequence_req[7:0]
                     + i_item.sequence_req[15:8] + i_item.payload_length;
    assign payload_sum = r_running_sum + i_item.payload_byte;

    always_comb begin
        if (i_item.op == bsfb_pkg::OpStart) begin
            count = (i_item.payload_length == 8'd0) ? bsfb_pkg::CntStartEmpty
                                                    : bsfb_pkg::CntStartOpen;
        end else if (r_frame_open && r_bytes_left == 8'd1) begin
            count = bsfb_pkg::CntTwo;
        end else begin
            count = bsfb_pkg::CntOne;
        end
    end

    assign last        = (r_idx == count - bsfb_pkg::CntOne);
    assign o_res_valid = i_item_valid;
    assign o_done      = i_item_valid && i_advance && last;

    // Result byte for the current slot.
    always_comb begin
        o_res = '0;
        if (i_item.op == bsfb_pkg::OpStart) begin
            case (r_idx)
                bsfb_pkg::SlotId:    o_res.out_byte = i_item.frame_id;
                bsfb_pkg::SlotSeqLo: o_res.out_byte = i_item.sequence_req[7:0];
                bsfb_pkg::SlotSeqHi: o_res.out_byte = i_item.sequence_req[15:8];
                bsfb_pkg::SlotLen:   o_res.out_byte = i_item.payload_length;
                bsfb_pkg::SlotSum: begin
                    o_res.out_byte  = start_sum;
                    o_res.frame_end = 1'b1;
                end
                default:             o_res.out_byte = 8'd0;
            endcase
        end else if (!r_frame_open) begin
            o_res.stray_byte = 1'b1;
        end else if (r_idx == '0) begin
            o_res.out_byte = i_item.payload_byte;
        end else begin
            o_res.out_byte  = payload_sum;
            o_res.frame_end = 1'b1;
        end
    end

    always_comb begin
        n_idx         = r_idx;
        n_frame_open  = r_frame_open;
        n_bytes_left  = r_bytes_left;
        n_running_sum = r_running_sum;
        if (i_item_valid && i_advance) begin
            if (last) begin
                n_idx = '0;
                if (i_item.op == bsfb_pkg::OpStart) begin
                    n_running_sum = start_sum;
                    n_bytes_left  = i_item.payload_length;
                    n_frame_open  = (i_item.payload_length != 8'd0);
                end else if (r_frame_open) begin
                    n_running_sum = payload_sum;
                    n_bytes_left  = r_bytes_left - 8'd1;
                    n_frame_open  = (r_bytes_left != 8'd1);
                end
            end else begin
                n_idx = r_idx + bsfb_pkg::CntOne;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_frame_open  <= 1'b0;
            r_bytes_left  <= 8'd0;
            r_running_sum <= 8'd0;
        end else begin
            r_idx         <= n_idx;
            r_frame_open  <= n_frame_open;
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
        end
    end

    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> r_bytes_left != 8'd0)
        else $error("open frame with no bytes left");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid |-> r_idx < count)
        else $error("result index past item end");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item_valid |-> r_idx == '0)
        else $error("result index not cleared while idle");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_idx == '0)
        else $error("result index kept after item end");

endmodule

// ----- design/bsfb_out_reg.sv -----
// Output register: loads a new result whenever it is empty or its transfer completes.
module bsfb_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  bsfb_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output bsfb_pkg::t_result o_res
);

    logic              r_valid;
    bsfb_pkg::t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- design/byte_sum_frame_builder.sv -----
// An item's first result passes through the input register and then the output register
// before its result transfer can take place.
// Throughput: one result byte per cycle unless the receiver stalls, set by the single
// output register. A payload byte gives one result byte (two when it closes the frame),
// a start item six (seven for a zero-length frame), and a stray payload byte one.
// Reset: synchronous, active low; clears the frame state, the item and result valids.
module byte_sum_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_frame_id,
    input  logic [15:0] i_sequence_req,
    input  logic [7:0]  i_payload_length,
    input  logic [7:0]  i_payload_byte,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_stray_byte
);

    // The input fields are bundled into one item for the input register.
    bsfb_pkg::t_item   in_item;
    bsfb_pkg::t_item   held_item;
    bsfb_pkg::t_result res;
    bsfb_pkg::t_result out_res;
    logic              held_valid;
    logic              res_valid;
    logic              item_done;
    logic              out_free;

    assign in_item.op             = i_op;
    assign in_item.frame_id       = i_frame_id;
    assign in_item.sequence_req   = i_sequence_req;
    assign in_item.payload_length = i_payload_length;
    assign in_item.payload_byte   = i_payload_byte;

    // The input register takes a new item in the same cycle that the held item
    // hands its last result to the output register, so payload bytes stream
    // through at one transfer per cycle while the receiver does not stall.
    bsfb_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .i_done       (item_done),
        .o_stall      (o_stall),
        .o_item_valid (held_valid),
        .o_item       (held_item)
    );

    // The emitter walks through the results of the held item, one each time the
    // output register can take a byte, and updates the open frame, the bytes
    // still expected and the running sum when the item's last result leaves.
    bsfb_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_advance    (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_done       (item_done)
    );

    // The output register separates the two sides: a finished byte can wait
    // there for its transfer while the next item is already accepted.
    bsfb_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_out_byte   = out_res.out_byte;
    assign o_frame_end  = out_res.frame_end;
    assign o_stray_byte = out_res.stray_byte;

endmodule

// ----- tb/byte_sum_frame_builder_tb.sv -----
module byte_sum_frame_builder_tb;

    // Predicts the framed byte stream from the accepted input items and
    // compares every result transfer with the oldest predicted byte.
    class frame_stream_checker;
        bit                frame_open;
        bit [7:0]          bytes_left;
        bit [7:0]          running_sum;
        bsfb_pkg::t_result expected_bytes[$];
        int                errors;

        function void push_byte(logic [7:0] value, logic is_end, logic is_stray);
            bsfb_pkg::t_result r;
            r.out_byte   = value;
            r.frame_end  = is_end;
            r.stray_byte = is_stray;
            expected_bytes.push_back(r);
        endfunction

        function void note_item(bsfb_pkg::t_item it);
            if (it.op == bsfb_pkg::OpStart) begin
                for (int i = 0; i < bsfb_pkg::HeaderZeros; i++) push_byte(8'h00, 1'b0, 1'b0);
                push_byte(it.frame_id, 1'b0, 1'b0);
                push_byte(it.sequence_req[7:0], 1'b0, 1'b0);
                push_byte(it.sequence_req[15:8], 1'b0, 1'b0);
                push_byte(it.payload_length, 1'b0, 1'b0);
                running_sum = it.frame_id + it.sequence_req[7:0] + it.sequence_req[15:8]
                              + it.payload_length;
                // An open frame is simply dropped; the new one replaces it.
                if (it.payload_length == 8'd0) begin
                    push_byte(running_sum, 1'b1, 1'b0);
                    frame_open = 1'b0;
                    bytes_left = 8'd0;
                end else begin
                    frame_open = 1'b1;
                    bytes_left = it.payload_length;
                end
            end else if (!frame_open) begin
                push_byte(8'h00, 1'b0, 1'b1);
            end else begin
                push_byte(it.payload_byte, 1'b0, 1'b0);
                running_sum = running_sum + it.payload_byte;
                bytes_left  = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    push_byte(running_sum, 1'b1, 1'b0);
                    frame_open = 1'b0;
                end
            end
        endfunction

        function void check_byte(bsfb_pkg::t_result got);
            bsfb_pkg::t_result want;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: byte %02h end %b stray %b",
                             got.out_byte, got.frame_end, got.stray_byte);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %02h end %b stray %b, got %02h end %b stray %b",
                             want.out_byte, want.frame_end, want.stray_byte,
                             got.out_byte, got.frame_end, got.stray_byte);
            end
        endfunction
    endclass

    // Cycles without any transfer on either channel before the run is
    // declared hung. A correct run never comes near this.
    localparam int WatchdogLimit = 1000;
    localparam int RandomItems   = 460;
    // The first result passes through the input and output registers before it can
    // transfer, so a short drain after the last predicted byte catches any extra output.
    localparam int DrainCycles   = 8;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic        i_op             = bsfb_pkg::OpStart;
    logic [7:0]  i_frame_id       = 8'h00;
    logic [15:0] i_sequence_req   = 16'h0000;
    logic [7:0]  i_payload_length = 8'h00;
    logic [7:0]  i_payload_byte   = 8'h00;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_frame_end;
    logic        o_stray_byte;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    // Both drop to zero for one stretch of the random part.
    int send_idle_pct = 34;
    int stall_pct     = 34;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    frame_stream_checker framer = new;

    byte_sum_frame_builder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_frame_id       (i_frame_id),
        .i_sequence_req   (i_sequence_req),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_frame_end      (o_frame_end),
        .o_stray_byte     (o_stray_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver decides its stall at each falling edge, so the value is
    // settled well before the rising edge that may complete a transfer.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor. The design updates its outputs with nonblocking
    // assignments, so reading them here sees the values from before the edge.
    // Predictions for an input transfer at this same edge cannot matter yet, since
    // its first result must still pass through the input and output registers.
    always @(posedge i_clk) begin
        bsfb_pkg::t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.out_byte   = o_out_byte;
            got.frame_end  = o_frame_end;
            got.stray_byte = o_stray_byte;
            framer.check_byte(got);
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bsfb_pkg::t_item start_item(logic [7:0] id, logic [15:0] seq,
                                                   logic [7:0] len);
        bsfb_pkg::t_item it;
        it.op             = bsfb_pkg::OpStart;
        it.frame_id       = id;
        it.sequence_req   = seq;
        it.payload_length = len;
        // Unused on a start, but kept random so every input bit moves.
        it.payload_byte   = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic bsfb_pkg::t_item payload_item(logic [7:0] value);
        bsfb_pkg::t_item it;
        it.op             = bsfb_pkg::OpPayload;
        it.frame_id       = 8'($urandom_range(255));
        it.sequence_req   = 16'($urandom_range(65535));
        it.payload_length = 8'($urandom_range(255));
        it.payload_byte   = value;
        return it;
    endfunction

    // Presents one item and holds it until the transfer completes. Entered
    // and left at a falling edge. Valid is lowered only during an idle gap,
    // so back-to-back items keep it high without a second assignment.
    task automatic send_item(input bsfb_pkg::t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_op             <= it.op;
        i_frame_id       <= it.frame_id;
        i_sequence_req   <= it.sequence_req;
        i_payload_length <= it.payload_length;
        i_payload_byte   <= it.payload_byte;
        do @(posedge i_clk); while (o_stall);
        framer.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // One frame with random content. Lengths are mostly short, with an
    // occasional empty or near-maximum frame. Some frames are cut short and
    // then abandoned by the next start. Near the end of the run the payload
    // is cut so the item count stays close to its target.
    task automatic send_random_frame();
        int pick;
        int len;
        int cut;
        pick = $urandom_range(99);
        if (pick < 4)       len = $urandom_range(200, 255);
        else if (pick < 14) len = 0;
        else                len = $urandom_range(1, 12);
        cut = len;
        if (len > 1 && $urandom_range(9) == 0) cut = $urandom_range(len - 1);
        if (cut > RandomItems - 1 - items_sent) cut = RandomItems - 1 - items_sent;
        if (cut < 0) cut = 0;
        send_item(start_item(8'($urandom_range(255)), 16'($urandom_range(65535)), 8'(len)));
        repeat (cut) send_item(payload_item(8'($urandom_range(255))));
    endtask

    initial begin
        int pick;
        bsfb_pkg::t_item it;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A payload byte right after reset has no frame.
        send_item(payload_item(8'hFF));
        // Empty frames: one whose checksum wraps, one that sums to zero.
        send_item(start_item(8'hFF, 16'hFFFF, 8'h00));
        send_item(start_item(8'h00, 16'h0000, 8'h00));
        // A one-byte frame, so its only payload byte also closes it.
        send_item(start_item(8'hA5, 16'h1234, 8'h01));
        send_item(payload_item(8'hFF));
        // A frame abandoned after one byte by a new start, which then completes.
        send_item(start_item(8'h3C, 16'h00FF, 8'h03));
        send_item(payload_item(8'h00));
        send_item(start_item(8'h5A, 16'h8001, 8'h02));
        send_item(payload_item(8'h80));
        send_item(payload_item(8'h7F));
        // Once the frame closes, payload bytes are stray again.
        send_item(payload_item(8'h55));
        send_item(payload_item(8'hAA));
        // Largest length, abandoned at once by an empty frame.
        send_item(start_item(8'hC3, 16'hFF00, 8'hFF));
        send_item(start_item(8'h01, 16'h7FFE, 8'h00));

        // Random part: mostly complete frames, the rest stray bytes and
        // fully random items.
        while (items_sent < RandomItems) begin
            if (items_sent >= 150 && items_sent < 260) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end else begin
                send_idle_pct = 34;
                stall_pct     = 34;
            end
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_random_frame();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) send_item(payload_item(8'($urandom_range(255))));
            end else begin
                it = payload_item(8'($urandom_range(255)));
                it.op = $urandom_range(1) ? bsfb_pkg::OpPayload : bsfb_pkg::OpStart;
                send_item(it);
            end
        end
        i_valid <= 1'b0;

        // Let every predicted byte arrive, then watch a little longer for
        // anything extra.
        while (framer.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);

        if (framer.expected_bytes.size() != 0) begin
            $display("%0d expected bytes never arrived", framer.expected_bytes.size());
            framer.errors += framer.expected_bytes.size();
        end
        if (framer.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bsfb_pkg.sv
design/bsfb_in_reg.sv
design/bsfb_emit.sv
design/bsfb_out_reg.sv
design/byte_sum_frame_builder.sv
tb/byte_sum_frame_builder_tb.sv
